// ===== rtl/core/bqup_pkg.sv =====
// ----------------------------------------------------------------------------
// bqup_pkg
// Shared types and constants for the two-queue upload planner.
// ----------------------------------------------------------------------------
package bqup_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SIZE_W          = 32;
  localparam int MIB_W           = 12;
  localparam int MIB_SHIFT       = 20;
  localparam logic [MIB_W-1:0] BUDGET_MIB_RST = MIB_W'(32);

  // result kinds
  localparam logic [1:0] RK_ENQ_STATUS = 2'd0;
  localparam logic [1:0] RK_ISSUED     = 2'd1;
  localparam logic [1:0] RK_DONE       = 2'd2;

  // enqueue status codes
  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_ZERO_SIZE  = 2'd1;
  localparam logic [1:0] ST_DROPPED    = 2'd2;

  // input kinds and categories
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;
  localparam logic CAT_HIGH     = 1'b0;
  localparam logic CAT_LOW      = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              category;
    logic [SIZE_W-1:0] size_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [1:0]        status;
    logic              job_category;
    logic [SIZE_W-1:0] job_size;
    logic [SIZE_W-1:0] budget_used;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN_HI,
    S_DRAIN_LO,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic enq;
    logic frame;
    logic pop_hi;
    logic pop_lo;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hi_fit;
    logic lo_fit;
  } stat_t;

endpackage

// ===== rtl/core/bqup_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqup_ctrl
// Sequencer: enqueue in idle, drain high queue, drain low queue, emit done.
// ----------------------------------------------------------------------------
module bqup_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_kind,
  input  bqup_pkg::stat_t   stat_i,
  output bqup_pkg::cmd_t    cmd_o,
  output logic              busy
);
  import bqup_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_kind == KIND_FRAME) begin
            cmd_o.frame = 1'b1;
            state_nxt   = S_DRAIN_HI;
          end else begin
            cmd_o.enq = 1'b1;
          end
        end
      end
      S_DRAIN_HI: begin
        // issue while the head fits, else move on to the low queue
        if (stat_i.hi_fit) begin
          cmd_o.pop_hi = 1'b1;
        end else begin
          state_nxt = S_DRAIN_LO;
        end
      end
      S_DRAIN_LO: begin
        if (stat_i.lo_fit) begin
          cmd_o.pop_lo = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bqup_datapath.sv =====
// ----------------------------------------------------------------------------
// bqup_datapath
// Two job FIFOs, budget register, used-byte accumulator and result register.
// ----------------------------------------------------------------------------
module bqup_datapath #(
  parameter int QUEUE_DEPTH = bqup_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bqup_pkg::in_item_t              in_item,
  input  bqup_pkg::cmd_t                  cmd_i,
  output bqup_pkg::stat_t                 stat_o,
  input  logic                            cfg_we,
  input  logic [bqup_pkg::MIB_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output bqup_pkg::out_item_t             out_item
);
  import bqup_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [SIZE_W-1:0] hi_mem [QUEUE_DEPTH];
  logic [SIZE_W-1:0] lo_mem [QUEUE_DEPTH];

  logic [PW-1:0]     hi_head_r, hi_tail_r, lo_head_r, lo_tail_r;
  logic [CW-1:0]     hi_cnt_r, lo_cnt_r;
  logic [SIZE_W-1:0] used_r;
  logic [MIB_W-1:0]  budget_mib_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [SIZE_W-1:0] hi_head_sz_r, lo_head_sz_r;

  logic [SIZE_W-1:0] budget_bytes;
  logic [PW-1:0]     hi_head_nxt, lo_head_nxt;
  logic [SIZE_W:0]   hi_sum, lo_sum;
  logic              enq_zero, enq_full, wr_hi, wr_lo;
  logic [1:0]        enq_status;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign budget_bytes = {budget_mib_r, {MIB_SHIFT{1'b0}}};
  assign hi_head_nxt  = cmd_i.pop_hi ? ptr_inc(hi_head_r) : hi_head_r;
  assign lo_head_nxt  = cmd_i.pop_lo ? ptr_inc(lo_head_r) : lo_head_r;
  assign hi_sum       = {1'b0, used_r} + {1'b0, hi_head_sz_r};
  assign lo_sum       = {1'b0, used_r} + {1'b0, lo_head_sz_r};

  assign stat_o.hi_fit = (hi_cnt_r != '0) && (hi_sum <= {1'b0, budget_bytes});
  assign stat_o.lo_fit = (lo_cnt_r != '0) && (lo_sum <= {1'b0, budget_bytes});

  // enqueue decision: zero size wins over full
  always_comb begin
    enq_zero = (in_item.size_bytes == '0);
    enq_full = (in_item.category == CAT_LOW) ? (lo_cnt_r == CNT_FULL)
                                             : (hi_cnt_r == CNT_FULL);
    if (enq_zero) begin
      enq_status = ST_ZERO_SIZE;
    end else if (enq_full) begin
      enq_status = ST_DROPPED;
    end else begin
      enq_status = ST_ACCEPTED;
    end
    wr_hi = cmd_i.enq && !enq_zero && !enq_full && (in_item.category == CAT_HIGH);
    wr_lo = cmd_i.enq && !enq_zero && !enq_full && (in_item.category == CAT_LOW);
  end

  // write at the tail; keep the head entry in a register, bypass a write
  // into an empty queue
  always_ff @(posedge clk) begin
    if (wr_hi) begin
      hi_mem[hi_tail_r] <= in_item.size_bytes;
    end
    if (wr_lo) begin
      lo_mem[lo_tail_r] <= in_item.size_bytes;
    end
    if (wr_hi && (hi_tail_r == hi_head_nxt)) begin
      hi_head_sz_r <= in_item.size_bytes;
    end else begin
      hi_head_sz_r <= hi_mem[hi_head_nxt];
    end
    if (wr_lo && (lo_tail_r == lo_head_nxt)) begin
      lo_head_sz_r <= in_item.size_bytes;
    end else begin
      lo_head_sz_r <= lo_mem[lo_head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_head_r    <= '0;
      hi_tail_r    <= '0;
      hi_cnt_r     <= '0;
      lo_head_r    <= '0;
      lo_tail_r    <= '0;
      lo_cnt_r     <= '0;
      used_r       <= '0;
      budget_mib_r <= BUDGET_MIB_RST;
    end else begin
      if (cfg_we) begin
        budget_mib_r <= cfg_wdata;
      end
      if (wr_hi) begin
        hi_tail_r <= ptr_inc(hi_tail_r);
        hi_cnt_r  <= hi_cnt_r + CW'(1);
      end
      if (wr_lo) begin
        lo_tail_r <= ptr_inc(lo_tail_r);
        lo_cnt_r  <= lo_cnt_r + CW'(1);
      end
      if (cmd_i.frame) begin
        used_r <= '0;
      end else if (cmd_i.pop_hi) begin
        used_r    <= hi_sum[SIZE_W-1:0];
        hi_head_r <= hi_head_nxt;
        hi_cnt_r  <= hi_cnt_r - CW'(1);
      end else if (cmd_i.pop_lo) begin
        used_r    <= lo_sum[SIZE_W-1:0];
        lo_head_r <= lo_head_nxt;
        lo_cnt_r  <= lo_cnt_r - CW'(1);
      end
    end
  end

  // result register: one strobe per result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.enq | cmd_i.pop_hi | cmd_i.pop_lo | cmd_i.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.enq) begin
      out_item_r.result_kind  <= RK_ENQ_STATUS;
      out_item_r.status       <= enq_status;
      out_item_r.job_category <= in_item.category;
      out_item_r.job_size     <= '0;
      out_item_r.budget_used  <= used_r;
      out_item_r.last         <= 1'b1;
    end else if (cmd_i.pop_hi) begin
      out_item_r.result_kind  <= RK_ISSUED;
      out_item_r.status       <= ST_ACCEPTED;
      out_item_r.job_category <= CAT_HIGH;
      out_item_r.job_size     <= hi_head_sz_r;
      out_item_r.budget_used  <= hi_sum[SIZE_W-1:0];
      out_item_r.last         <= 1'b0;
    end else if (cmd_i.pop_lo) begin
      out_item_r.result_kind  <= RK_ISSUED;
      out_item_r.status       <= ST_ACCEPTED;
      out_item_r.job_category <= CAT_LOW;
      out_item_r.job_size     <= lo_head_sz_r;
      out_item_r.budget_used  <= lo_sum[SIZE_W-1:0];
      out_item_r.last         <= 1'b0;
    end else if (cmd_i.done) begin
      out_item_r.result_kind  <= RK_DONE;
      out_item_r.status       <= ST_ACCEPTED;
      out_item_r.job_category <= CAT_HIGH;
      out_item_r.job_size     <= '0;
      out_item_r.budget_used  <= used_r;
      out_item_r.last         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/budgeted_two_queue_upload_planner.sv =====
// ----------------------------------------------------------------------------
// budgeted_two_queue_upload_planner
// Strict-priority planner over two job FIFOs with a per-frame byte budget.
// ----------------------------------------------------------------------------
//   channel  ports                          direction  handshake
//   input    start, busy, in_item           in         start & !busy
//   result   out_valid, out_item            out        out_valid, one cycle
//   config   cfg_we, cfg_wdata              in         cfg_we
//
// An enqueue item keeps busy low, and its status result shows on the cycle
// after acceptance. A frame item is accepted, then busy stays high while the
// planner issues one job per cycle out of the FIFO heads, switches to the low
// FIFO, leaves it and emits the done result. The budget add-and-compare on
// the registered FIFO head sets that one-job-per-cycle pace.
// Reset (rst_n low, synchronous) empties both queues, clears the accumulator
// and loads a 32 MiB budget. The receiver cannot stall: each result is
// valid for exactly one cycle.
// ----------------------------------------------------------------------------
module budgeted_two_queue_upload_planner #(
  parameter int QUEUE_DEPTH = bqup_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  bqup_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output bqup_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [bqup_pkg::MIB_W-1:0]  cfg_wdata
);
  import bqup_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decides what the datapath does each cycle
  bqup_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  // queues, budget and result register
  bqup_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
